FILE: hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int unsigned CAU_FRAC_BITS = 8;

    localparam int unsigned OP_W  = 16;
    localparam int unsigned PROD_W = 2 * OP_W;
    localparam int unsigned PW    = PROD_W + 2;
    localparam int unsigned DEN_W = PROD_W;
    localparam int unsigned QW    = OP_W;
    // wide enough for the scaled numerator with FRAC_BITS up to QW and for den << QW
    localparam int unsigned REM_W = DEN_W + QW;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cau_cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SAT      = 2'd1,
        ST_DIV_ZERO = 2'd2
    } cau_status_t;

    typedef struct packed {
        cau_cmd_t                cmd;
        logic signed [PW-1:0]    pre_re;
        logic signed [PW-1:0]    pre_im;
        logic                    dz;
        logic                    ovf_re;
        logic                    ovf_im;
        logic                    neg_re;
        logic                    neg_im;
        logic [REM_W-1:0]        rem_re;
        logic [REM_W-1:0]        rem_im;
        logic [QW-1:0]           q_re;
        logic [QW-1:0]           q_im;
        logic [DEN_W-1:0]        den;
    } cau_div_t;

    typedef struct packed {
        logic [OP_W-1:0] value;
        logic            sat;
    } cau_clamp_t;

    function automatic cau_clamp_t clamp16(input logic signed [PW-1:0] v);
        cau_clamp_t r;
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'($signed({1'b0, {(OP_W-1){1'b1}}}));
        lo = PW'($signed({1'b1, {(OP_W-1){1'b0}}}));
        if (v > hi) begin
            r.value = hi[OP_W-1:0];
            r.sat   = 1'b1;
        end else if (v < lo) begin
            r.value = lo[OP_W-1:0];
            r.sat   = 1'b1;
        end else begin
            r.value = v[OP_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cau_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module cau_div_stage #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire cau_pkg::cau_div_t in_data,
    output logic                  out_valid,
    output cau_pkg::cau_div_t     out_data
);
    import cau_pkg::*;

    logic             valid_reg;
    cau_div_t         data_reg;
    cau_div_t         data_next;
    logic [REM_W-1:0] trial;

    // one restoring step per part, quotient bit SHIFT
    always_comb begin
        trial     = REM_W'(in_data.den) << SHIFT;
        data_next = in_data;
        if (in_data.rem_re >= trial) begin
            data_next.rem_re      = in_data.rem_re - trial;
            data_next.q_re[SHIFT] = 1'b1;
        end
        if (in_data.rem_im >= trial) begin
            data_next.rem_im      = in_data.rem_im - trial;
            data_next.q_im[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  ports        fields (lsb first)
// s_axis   in   tdata[71:0]  cmd[1:0], a_real, a_imag, b_real, b_imag
// m_axis   out  tdata[39:0]  res_real, res_imag, status[1:0]
//
// one transfer accepted per cycle unless a stall on m_axis backs up the pipeline; every command
// takes the same path (products, sums, scaling, overflow test, 16 restoring divide steps, clamp)
// each stage holds its item until the next frees up, so bubbles close and a
// stall on m_axis loses nothing; aresetn clears only the valid bits

module complex_arithmetic_unit_core #(
    parameter int unsigned FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd[1:0], a_real[17:2], a_imag[33:18], b_real[49:34], b_imag[65:50]
    input  wire logic [cau_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // res_real[15:0], res_imag[31:16], status[33:32]
    output logic [cau_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import cau_pkg::*;

    logic signed [OP_W-1:0] ar, ai, br, bi;
    cau_cmd_t               in_cmd;

    assign in_cmd = cau_cmd_t'(s_axis_tdata[1:0]);
    assign ar     = $signed(s_axis_tdata[17:2]);
    assign ai     = $signed(s_axis_tdata[33:18]);
    assign br     = $signed(s_axis_tdata[49:34]);
    assign bi     = $signed(s_axis_tdata[65:50]);

    // stage 1: products and add/sub
    logic                     v1_reg;
    cau_cmd_t                 cmd1_reg;
    logic signed [OP_W:0]     as_re1_reg, as_im1_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_jj_reg;

    // stage 2: sums
    logic                     v2_reg;
    cau_cmd_t                 cmd2_reg;
    logic signed [OP_W:0]     as_re2_reg, as_im2_reg;
    logic signed [PROD_W:0]   mul_re2_reg, mul_im2_reg, num_re2_reg, num_im2_reg;
    logic [DEN_W-1:0]         den2_reg;

    // stage 3: scaling and magnitudes
    logic                     v3_reg;
    cau_cmd_t                 cmd3_reg;
    logic signed [PW-1:0]     pre_re3_reg, pre_im3_reg;
    logic                     neg_re3_reg, neg_im3_reg;
    logic [REM_W-1:0]         mag_re3_reg, mag_im3_reg;
    logic [DEN_W-1:0]         den3_reg;

    // stage 4 feeds the divide chain
    logic                     v4_reg;
    cau_div_t                 d4_reg;

    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    logic [QW:0]              dv;
    cau_div_t                 dd [QW+1];
    logic [QW+1:0]            div_en;
    logic                     e1, e2, e3, out_en;

    assign out_en = !m_valid_reg || m_axis_tready;

    always_comb begin
        div_en[QW+1] = out_en;
        for (int k = QW; k >= 1; k--) begin
            div_en[k] = !dv[k] || div_en[k+1];
        end
        div_en[0] = !v4_reg || div_en[1];
    end

    assign e3 = !v3_reg || div_en[0];
    assign e2 = !v2_reg || e3;
    assign e1 = !v1_reg || e2;
    assign s_axis_tready = e1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (e1)        v1_reg      <= s_axis_tvalid;
            if (e2)        v2_reg      <= v1_reg;
            if (e3)        v3_reg      <= v2_reg;
            if (div_en[0]) v4_reg      <= v3_reg;
            if (out_en)    m_valid_reg <= dv[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (e1) begin
            cmd1_reg   <= in_cmd;
            as_re1_reg <= (in_cmd == CMD_SUB) ? (OP_W+1)'(ar) - (OP_W+1)'(br)
                                              : (OP_W+1)'(ar) + (OP_W+1)'(br);
            as_im1_reg <= (in_cmd == CMD_SUB) ? (OP_W+1)'(ai) - (OP_W+1)'(bi)
                                              : (OP_W+1)'(ai) + (OP_W+1)'(bi);
            p_rr_reg   <= ar * br;
            p_ii_reg   <= ai * bi;
            p_ri_reg   <= ar * bi;
            p_ir_reg   <= ai * br;
            p_bb_reg   <= br * br;
            p_jj_reg   <= bi * bi;
        end
    end

    always_ff @(posedge aclk) begin
        if (e2) begin
            cmd2_reg    <= cmd1_reg;
            as_re2_reg  <= as_re1_reg;
            as_im2_reg  <= as_im1_reg;
            mul_re2_reg <= (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
            mul_im2_reg <= (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
            num_re2_reg <= (PROD_W+1)'(p_rr_reg) + (PROD_W+1)'(p_ii_reg);
            num_im2_reg <= (PROD_W+1)'(p_ir_reg) - (PROD_W+1)'(p_ri_reg);
            den2_reg    <= DEN_W'($unsigned(p_bb_reg)) + DEN_W'($unsigned(p_jj_reg));
        end
    end

    logic signed [PW-1:0]   bias, mre_x, mim_x;
    logic signed [PROD_W:0] nre_abs, nim_abs;

    always_comb begin
        bias    = (PW'($signed(2'sb01)) <<< FRAC_BITS) - PW'($signed(2'sb01));
        mre_x   = PW'(mul_re2_reg);
        mim_x   = PW'(mul_im2_reg);
        // truncation toward zero for negative products
        if (mre_x < 0) mre_x = mre_x + bias;
        if (mim_x < 0) mim_x = mim_x + bias;
        nre_abs = (num_re2_reg < 0) ? -num_re2_reg : num_re2_reg;
        nim_abs = (num_im2_reg < 0) ? -num_im2_reg : num_im2_reg;
    end

    always_ff @(posedge aclk) begin
        if (e3) begin
            cmd3_reg    <= cmd2_reg;
            if (cmd2_reg == CMD_MUL) begin
                pre_re3_reg <= mre_x >>> FRAC_BITS;
                pre_im3_reg <= mim_x >>> FRAC_BITS;
            end else begin
                pre_re3_reg <= PW'(as_re2_reg);
                pre_im3_reg <= PW'(as_im2_reg);
            end
            neg_re3_reg <= num_re2_reg < 0;
            neg_im3_reg <= num_im2_reg < 0;
            mag_re3_reg <= REM_W'($unsigned(nre_abs[PROD_W-1:0])) << FRAC_BITS;
            mag_im3_reg <= REM_W'($unsigned(nim_abs[PROD_W-1:0])) << FRAC_BITS;
            den3_reg    <= den2_reg;
        end
    end

    logic [REM_W-1:0] den_top;
    assign den_top = REM_W'(den3_reg) << QW;

    always_ff @(posedge aclk) begin
        if (div_en[0]) begin
            d4_reg.cmd    <= cmd3_reg;
            d4_reg.pre_re <= pre_re3_reg;
            d4_reg.pre_im <= pre_im3_reg;
            d4_reg.dz     <= den3_reg == '0;
            // quotient would not fit in QW bits
            d4_reg.ovf_re <= mag_re3_reg >= den_top;
            d4_reg.ovf_im <= mag_im3_reg >= den_top;
            d4_reg.neg_re <= neg_re3_reg;
            d4_reg.neg_im <= neg_im3_reg;
            d4_reg.rem_re <= mag_re3_reg;
            d4_reg.rem_im <= mag_im3_reg;
            d4_reg.q_re   <= '0;
            d4_reg.q_im   <= '0;
            d4_reg.den    <= den3_reg;
        end
    end

    assign dv[0] = v4_reg;
    assign dd[0] = d4_reg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        cau_div_stage #(
            .SHIFT (QW - 1 - k)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (div_en[k+1]),
            .in_valid  (dv[k]),
            .in_data   (dd[k]),
            .out_valid (dv[k+1]),
            .out_data  (dd[k+1])
        );
    end

    // final sign, clamp and status
    cau_div_t             fin;
    logic signed [PW-1:0] v_re, v_im;
    cau_clamp_t           c_re, c_im;
    logic [M_TDATA_W-1:0] m_data_next;

    always_comb begin
        fin = dd[QW];
        if (fin.cmd == CMD_DIV) begin
            v_re = fin.neg_re ? -PW'({2'b00, fin.q_re}) : PW'({2'b00, fin.q_re});
            v_im = fin.neg_im ? -PW'({2'b00, fin.q_im}) : PW'({2'b00, fin.q_im});
            if (fin.ovf_re) v_re = fin.neg_re ? -(PW'(1) <<< (QW + 1)) : (PW'(1) <<< (QW + 1));
            if (fin.ovf_im) v_im = fin.neg_im ? -(PW'(1) <<< (QW + 1)) : (PW'(1) <<< (QW + 1));
        end else begin
            v_re = fin.pre_re;
            v_im = fin.pre_im;
        end
        c_re = clamp16(v_re);
        c_im = clamp16(v_im);
        m_data_next = '0;
        if (fin.cmd == CMD_DIV && fin.dz) begin
            m_data_next[33:32] = ST_DIV_ZERO;
        end else begin
            m_data_next[15:0]  = c_re.value;
            m_data_next[31:16] = c_im.value;
            m_data_next[33:32] = (c_re.sat || c_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire
